// File: design/assert_macros.svh
// Assertion macros shared by the Hill cipher encryptor modules.
// They expect aclk and the active-low aresetn in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HCB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hill cipher check failed");

// next-cycle implication
`define HCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hill cipher check failed");

`endif

// File: design/hcb_pkg.sv
// Types, constants and the modulo-26 reduction for the Hill cipher encryptor.
// No dependencies.
package hcb_pkg;

    localparam int SYM_W    = 5;
    localparam int KEY_COLS = 4;
    localparam int ROW_W    = 2;
    localparam int CNT_W    = 3;
    localparam int KEY_W    = SYM_W * KEY_COLS;
    localparam int SUM_W    = 10;
    localparam int CFG_W    = 3;

    localparam logic [SYM_W-1:0] MODULUS    = 5'd26;
    localparam logic [SYM_W-1:0] PAD_SYMBOL = 5'd23;

    localparam logic [CFG_W-1:0] CFG_BLOCK_SIZE = 3'd0;
    localparam logic [CFG_W-1:0] CFG_KEY_ROW_A  = 3'd1;
    localparam logic [CFG_W-1:0] CFG_KEY_ROW_B  = 3'd2;
    localparam logic [CFG_W-1:0] CFG_KEY_ROW_C  = 3'd3;
    localparam logic [CFG_W-1:0] CFG_KEY_ROW_D  = 3'd4;

    localparam logic [CNT_W-1:0] BLOCK_SIZE_RESET = 3'd2;

    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [KEY_COLS-1:0][KEY_W-1:0] key_rows_t;

    // identity key
    localparam key_rows_t KEY_RESET = {20'd32768, 20'd1024, 20'd32, 20'd1};

    // one row of a block on its way down the chain
    typedef struct packed {
        logic                 valid;
        logic [ROW_W-1:0]     row;
        logic [CNT_W-1:0]     size;
        logic                 block_end;
        logic                 message_end;
        sym_t                 acc;
        sym_t [KEY_COLS-1:0]  vec;
    } hcb_pkt_t;

    // x mod 26 for x below 1024: reciprocal estimate 157/4096 runs low by at
    // most one, so a single compare and subtract finishes it
    function automatic sym_t mod26(input logic [SUM_W-1:0] x);
        logic [SUM_W+7:0] prod;
        logic [5:0]       q;
        logic [SUM_W-1:0] r;
        prod = {8'b0, x} * 18'd157;
        q    = prod[SUM_W+7:12];
        r    = x - ({4'b0, q} * 10'd26);
        if (r >= {5'b0, MODULUS}) begin
            r = r - {5'b0, MODULUS};
        end
        return r[SYM_W-1:0];
    endfunction

endpackage

// File: design/hill_cipher_block_encrypt.sv
// Hill cipher encryptor: one symbol word in and one cipher word out per cycle when not stalled.
// The first cipher word of a block shows on m_ once its row has passed the launcher
// and every cell register; rows then follow every cycle unless m_ready stalls them.
// A word that completes a block waits while the rows of the previous block are
// still being issued (when it ends a message early or the block size was lowered)
// or while m_ready holds the chain. aresetn (synchronous) empties the chain, clears
// the fill count, block size 2, identity key.
module hill_cipher_block_encrypt
    import hcb_pkg::*;
#(
    parameter int MAX_BLOCK = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sym_t             s_symbol,
    input  logic             s_message_last,
    output logic             m_valid,
    input  logic             m_ready,
    output sym_t             m_cipher_symbol,
    output logic             m_block_end,
    output logic             m_message_end,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_index,
    input  logic [KEY_W-1:0] cfg_data
);

    logic [CNT_W-1:0] block_size_reg;
    key_rows_t        key_rows_reg;
    hcb_pkt_t         chain [MAX_BLOCK+1];
    logic             advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= BLOCK_SIZE_RESET;
            key_rows_reg   <= KEY_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BLOCK_SIZE: block_size_reg  <= cfg_data[CNT_W-1:0];
                CFG_KEY_ROW_A:  key_rows_reg[0] <= cfg_data;
                CFG_KEY_ROW_B:  key_rows_reg[1] <= cfg_data;
                CFG_KEY_ROW_C:  key_rows_reg[2] <= cfg_data;
                CFG_KEY_ROW_D:  key_rows_reg[3] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // whole chain moves together; hold it while the output word waits
    assign advance = m_ready || !chain[MAX_BLOCK].valid;

    hcb_launch #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_launch (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .block_size     (block_size_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_symbol       (s_symbol),
        .s_message_last (s_message_last),
        .pkt_out        (chain[0])
    );

    for (genvar g = 0; g < MAX_BLOCK; g++) begin : g_cell
        hcb_cell #(
            .COL (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .key_rows (key_rows_reg),
            .pkt_in   (chain[g]),
            .pkt_out  (chain[g+1])
        );
    end

    assign m_valid         = chain[MAX_BLOCK].valid;
    assign m_cipher_symbol = chain[MAX_BLOCK].acc;
    assign m_block_end     = chain[MAX_BLOCK].block_end;
    assign m_message_end   = chain[MAX_BLOCK].message_end;

`include "assert_macros.svh"

    `HCB_ASSERT_NEXT(a_rows_back_to_back, m_valid && m_ready && !m_block_end, m_valid)
    `HCB_ASSERT_NOW(a_msg_end_on_block_end, m_valid && m_message_end, m_block_end)

endmodule

// File: design/hcb_cell.sv
// One column cell of the Hill cipher chain: if COL is below the block size, adds
// key[row][COL] * symbol[COL] to the running sum and reduces modulo 26; hands the row on. Uses hcb_pkg.
module hcb_cell
    import hcb_pkg::*;
#(
    parameter int COL = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  key_rows_t key_rows,
    input  hcb_pkt_t  pkt_in,
    output hcb_pkt_t  pkt_out
);

    sym_t             key_ent;
    logic [SUM_W-1:0] sum;
    hcb_pkt_t         pkt_reg;
    hcb_pkt_t         pkt_next;

    // unreduced key entry is fine: the sum is reduced anyway
    assign key_ent = key_rows[pkt_in.row][SYM_W*COL +: SYM_W];
    assign sum     = {5'b0, pkt_in.acc} + ({5'b0, key_ent} * {5'b0, pkt_in.vec[COL]});

    always_comb begin
        pkt_next = pkt_in;
        if (CNT_W'(COL) < pkt_in.size) begin
            pkt_next.acc = mod26(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_reg.valid <= 1'b0;
        end else if (advance) begin
            pkt_reg <= pkt_next;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

// File: design/hcb_launch.sv
// Symbol collector and row launcher: gathers a block, pads it on message end
// and feeds its rows into the cell chain one per cycle when advance is high. Uses hcb_pkg.
module hcb_launch
    import hcb_pkg::*;
#(
    parameter int MAX_BLOCK = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [CNT_W-1:0] block_size,
    input  logic             s_valid,
    output logic             s_ready,
    input  sym_t             s_symbol,
    input  logic             s_message_last,
    output hcb_pkt_t         pkt_out
);

    sym_t                hold_reg [MAX_BLOCK];
    logic [CNT_W-1:0]    fill_reg;
    logic                busy_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [CNT_W-1:0]    size_reg;
    logic                last_reg;
    sym_t [KEY_COLS-1:0] vec_reg;

    sym_t [KEY_COLS-1:0] vec_next;
    logic [CNT_W-1:0]    eff_size;
    logic [CNT_W-1:0]    fill_inc;
    logic                complete;
    logic                last_row;
    logic                accept;

    always_comb begin
        if (block_size == '0) begin
            eff_size = CNT_W'(1);
        end else if (block_size > CNT_W'(MAX_BLOCK)) begin
            eff_size = CNT_W'(MAX_BLOCK);
        end else begin
            eff_size = block_size;
        end
    end

    assign fill_inc = fill_reg + CNT_W'(1);
    assign complete = (fill_inc >= eff_size) || s_message_last;
    assign last_row = ({1'b0, row_reg} == (size_reg - CNT_W'(1)));
    // hold a word that completes a block until the launcher frees up in this cycle
    assign s_ready  = !busy_reg || (advance && last_row) || !complete;
    assign accept   = s_valid && s_ready;

    // held symbols, then the incoming word, then padding
    always_comb begin
        for (int c = 0; c < KEY_COLS; c++) begin
            vec_next[c] = PAD_SYMBOL;
        end
        for (int c = 0; c < MAX_BLOCK; c++) begin
            if (CNT_W'(c) < fill_reg) begin
                vec_next[c] = hold_reg[c];
            end else if (CNT_W'(c) == fill_reg) begin
                vec_next[c] = s_symbol;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < MAX_BLOCK; c++) begin
            if (accept && fill_reg == CNT_W'(c)) begin
                hold_reg[c] <= s_symbol;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else begin
            if (accept) begin
                fill_reg <= complete ? '0 : fill_inc;
            end
            if (accept && complete) begin
                busy_reg <= 1'b1;
                row_reg  <= '0;
            end else if (busy_reg && advance) begin
                row_reg <= row_reg + ROW_W'(1);
                if (last_row) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && complete) begin
            size_reg <= eff_size;
            last_reg <= s_message_last;
            vec_reg  <= vec_next;
        end
    end

    always_comb begin
        pkt_out.valid       = busy_reg;
        pkt_out.row         = row_reg;
        pkt_out.size        = size_reg;
        pkt_out.block_end   = last_row;
        pkt_out.message_end = last_row && last_reg;
        pkt_out.acc         = '0;
        pkt_out.vec         = vec_reg;
    end

`include "assert_macros.svh"

    `HCB_ASSERT_NEXT(a_load_starts_row0, accept && complete, busy_reg && row_reg == '0)
    `HCB_ASSERT_NEXT(a_load_clears_fill, accept && complete, fill_reg == '0)

endmodule
